// ===== rtl/sm_dsa_pkg.sv =====
// ----------------------------------------------------------------------------
// sm_dsa_pkg
// Shared types and constants of the data stack ALU.
// ----------------------------------------------------------------------------
package sm_dsa_pkg;

  localparam int unsigned StackDepthDefault = 256;
  localparam int unsigned CellWidthDefault  = 64;
  localparam int unsigned PortWidth         = 64;
  localparam int unsigned DepthWidth        = 9;

  typedef enum logic [4:0] {
    CMD_PUSH   = 5'd0,
    CMD_ADD    = 5'd1,
    CMD_SUB    = 5'd2,
    CMD_MUL    = 5'd3,
    CMD_DIV    = 5'd4,
    CMD_MOD    = 5'd5,
    CMD_DUP    = 5'd6,
    CMD_DROP   = 5'd7,
    CMD_SWAP   = 5'd8,
    CMD_OVER   = 5'd9,
    CMD_ROT    = 5'd10,
    CMD_EQ     = 5'd11,
    CMD_LT     = 5'd12,
    CMD_GT     = 5'd13,
    CMD_INVERT = 5'd14,
    CMD_AND    = 5'd15,
    CMD_OR     = 5'd16,
    CMD_PRINT  = 5'd17,
    CMD_EMIT   = 5'd18
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_DIV_ZERO  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PK_NONE = 2'd0,
    PK_NUM  = 2'd1,
    PK_CHAR = 2'd2
  } print_kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_RD3,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_WR2,
    S_WR3,
    S_TOP,
    S_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic is_mod;
  } div_req_t;

endpackage

// ===== rtl/sm_dsa_div.sv =====
// ----------------------------------------------------------------------------
// sm_dsa_div
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sm_dsa_div import sm_dsa_pkg::*; #(
  parameter int unsigned CellWidth = CellWidthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  div_req_t             req_i,
  input  logic [CellWidth-1:0] num_i,
  input  logic [CellWidth-1:0] den_i,
  output logic                 done_o,
  output logic [CellWidth-1:0] res_o
);

  localparam int unsigned CntW = $clog2(CellWidth + 1);

  logic [CellWidth-1:0] quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d, mod_q, mod_d;
  logic                 sa_q, sa_d, sb_q, sb_d;
  logic [CellWidth:0]   trial;
  logic [CellWidth-1:0] mag_r;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    mod_d  = mod_q;
    sa_d   = sa_q;
    sb_d   = sb_q;
    trial  = {rem_q, quo_q[CellWidth-1]} - {1'b0, den_q};
    if (req_i.start) begin
      sa_d   = num_i[CellWidth-1];
      sb_d   = den_i[CellWidth-1];
      quo_d  = num_i[CellWidth-1] ? (~num_i + 1'b1) : num_i;
      den_d  = den_i[CellWidth-1] ? (~den_i + 1'b1) : den_i;
      rem_d  = '0;
      cnt_d  = CntW'(CellWidth);
      busy_d = 1'b1;
      mod_d  = req_i.is_mod;
    end else if (busy_q) begin
      if (trial[CellWidth]) begin
        rem_d = {rem_q[CellWidth-2:0], quo_q[CellWidth-1]};
        quo_d = {quo_q[CellWidth-2:0], 1'b0};
      end else begin
        rem_d = trial[CellWidth-1:0];
        quo_d = {quo_q[CellWidth-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    mod_q <= mod_d;
    sa_q  <= sa_d;
    sb_q  <= sb_d;
  end

  assign mag_r  = mod_q ? rem_q : quo_q;
  assign res_o  = (mod_q ? sa_q : (sa_q ^ sb_q)) ? (~mag_r + 1'b1) : mag_r;
  assign done_o = done_q;

endmodule

// ===== rtl/sm_dsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// sm_dsa_ctrl
// Sequencer: reads operands from the stack memory, executes, writes back.
// ----------------------------------------------------------------------------
module sm_dsa_ctrl import sm_dsa_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDefault,
  parameter int unsigned CellWidth  = CellWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [4:0]            cmd_i,
  input  logic [PortWidth-1:0]  literal_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PortWidth-1:0]  top_value_o,
  output logic [DepthWidth-1:0] stack_depth_o,
  output logic [1:0]            status_o,
  output logic [1:0]            print_kind_o,
  output logic [PortWidth-1:0]  printed_value_o
);

  localparam int unsigned AddrW = $clog2(StackDepth);
  localparam int unsigned SpW   = $clog2(StackDepth + 1);

  logic [CellWidth-1:0] mem [StackDepth];
  logic [CellWidth-1:0] rdata_q;
  logic                 re, we;
  logic [AddrW-1:0]     raddr, waddr;
  logic [CellWidth-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  state_e               state_q, state_d;
  logic [SpW-1:0]       sp_q, sp_d;
  logic [4:0]           cmd_q, cmd_d;
  logic [CellWidth-1:0] lit_q, lit_d, a_q, a_d, b_q, b_d, c_q, c_d;
  logic [CellWidth-1:0] r_q, r_d, prn_q, prn_d;
  logic [1:0]           st_q, st_d, pk_q, pk_d;
  logic [1:0]           mcnt_q, mcnt_d;
  logic [63:0]          mul_a, mul_b, mprod_q, acc_q, acc_d;
  logic [31:0]          mop_a, mop_b;
  div_req_t             dreq;
  logic                 ddone;
  logic [CellWidth-1:0] dres;
  logic [1:0]           need;
  logic                 grow, known;
  logic [CellWidth-1:0] ones;

  sm_dsa_div #(.CellWidth(CellWidth)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .num_i  (a_q),
    .den_i  (b_q),
    .done_o (ddone),
    .res_o  (dres)
  );

  assign mul_a = 64'(a_q);
  assign mul_b = 64'(b_q);

  always_comb begin
    case (mcnt_q)
      2'd0: begin
        mop_a = mul_a[31:0];
        mop_b = mul_b[31:0];
      end
      2'd1: begin
        mop_a = mul_a[31:0];
        mop_b = mul_b[63:32];
      end
      default: begin
        mop_a = mul_a[63:32];
        mop_b = mul_b[31:0];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mprod_q <= mop_a * mop_b;
  end

  assign ones = '1;

  always_comb begin
    need  = 2'd0;
    grow  = 1'b0;
    known = 1'b1;
    case (cmd_q)
      CMD_PUSH:  grow = 1'b1;
      CMD_DUP:   begin need = 2'd1; grow = 1'b1; end
      CMD_OVER:  begin need = 2'd2; grow = 1'b1; end
      CMD_ROT:   need = 2'd3;
      CMD_DROP, CMD_INVERT, CMD_PRINT, CMD_EMIT: need = 2'd1;
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_SWAP,
      CMD_EQ, CMD_LT, CMD_GT, CMD_AND, CMD_OR: need = 2'd2;
      default:   known = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    sp_d    = sp_q;
    cmd_d   = cmd_q;
    lit_d   = lit_q;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    r_d     = r_q;
    prn_d   = prn_q;
    st_d    = st_q;
    pk_d    = pk_q;
    mcnt_d  = mcnt_q;
    acc_d   = acc_q;
    re      = 1'b0;
    raddr   = '0;
    we      = 1'b0;
    waddr   = '0;
    wdata   = r_q;
    dreq    = '{start: 1'b0, is_mod: 1'b0};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_i;
          lit_d   = literal_value_i[CellWidth-1:0];
          st_d    = ST_OK;
          pk_d    = PK_NONE;
          prn_d   = '0;
          state_d = S_RD1;
        end
      end
      S_RD1: begin
        if (!known) begin
          state_d = S_TOP;
        end else if (sp_q < SpW'(need)) begin
          st_d    = ST_UNDERFLOW;
          state_d = S_TOP;
        end else if (grow && sp_q >= SpW'(StackDepth)) begin
          st_d    = ST_OVERFLOW;
          state_d = S_TOP;
        end else begin
          re      = 1'b1;
          raddr   = AddrW'(sp_q - 1'b1);
          state_d = S_RD2;
        end
      end
      S_RD2: begin
        b_d     = rdata_q;
        re      = 1'b1;
        raddr   = AddrW'(sp_q - 2'd2);
        state_d = S_RD3;
      end
      S_RD3: begin
        a_d     = rdata_q;
        re      = 1'b1;
        raddr   = AddrW'(sp_q - 2'd3);
        state_d = S_EXEC;
      end
      S_EXEC: begin
        c_d     = rdata_q;
        state_d = S_TOP;
        case (cmd_q)
          CMD_PUSH: begin
            we = 1'b1; waddr = AddrW'(sp_q); wdata = lit_q; sp_d = sp_q + 1'b1;
          end
          CMD_ADD: begin
            we = 1'b1; waddr = AddrW'(sp_q - 2'd2); wdata = a_q + b_q;
            sp_d = sp_q - 1'b1;
          end
          CMD_SUB: begin
            we = 1'b1; waddr = AddrW'(sp_q - 2'd2); wdata = a_q - b_q;
            sp_d = sp_q - 1'b1;
          end
          CMD_MUL: begin
            mcnt_d  = '0;
            state_d = S_MUL;
          end
          CMD_DIV, CMD_MOD: begin
            if (b_q == '0) begin
              st_d = ST_DIV_ZERO;
            end else begin
              dreq    = '{start: 1'b1, is_mod: (cmd_q == CMD_MOD)};
              state_d = S_DIV;
            end
          end
          CMD_DUP: begin
            we = 1'b1; waddr = AddrW'(sp_q); wdata = b_q; sp_d = sp_q + 1'b1;
          end
          CMD_DROP: sp_d = sp_q - 1'b1;
          CMD_SWAP: begin
            we = 1'b1; waddr = AddrW'(sp_q - 2'd2); wdata = b_q;
            r_d = a_q; state_d = S_WR2;
          end
          CMD_OVER: begin
            we = 1'b1; waddr = AddrW'(sp_q); wdata = a_q; sp_d = sp_q + 1'b1;
          end
          CMD_ROT: begin
            we = 1'b1; waddr = AddrW'(sp_q - 2'd3); wdata = a_q;
            r_d = b_q; state_d = S_WR3;
          end
          CMD_EQ, CMD_LT, CMD_GT: begin
            we = 1'b1; waddr = AddrW'(sp_q - 2'd2);
            if (cmd_q == CMD_EQ) begin
              wdata = (a_q == b_q) ? ones : '0;
            end else if (cmd_q == CMD_LT) begin
              wdata = ($signed(a_q) < $signed(b_q)) ? ones : '0;
            end else begin
              wdata = ($signed(b_q) < $signed(a_q)) ? ones : '0;
            end
            sp_d = sp_q - 1'b1;
          end
          CMD_INVERT: begin
            we = 1'b1; waddr = AddrW'(sp_q - 1'b1); wdata = ~b_q;
          end
          CMD_AND: begin
            we = 1'b1; waddr = AddrW'(sp_q - 2'd2); wdata = a_q & b_q;
            sp_d = sp_q - 1'b1;
          end
          CMD_OR: begin
            we = 1'b1; waddr = AddrW'(sp_q - 2'd2); wdata = a_q | b_q;
            sp_d = sp_q - 1'b1;
          end
          CMD_PRINT, CMD_EMIT: begin
            pk_d  = (cmd_q == CMD_PRINT) ? PK_NUM : PK_CHAR;
            prn_d = b_q;
            sp_d  = sp_q - 1'b1;
          end
          default: ;
        endcase
      end
      S_MUL: begin
        mcnt_d = mcnt_q + 1'b1;
        case (mcnt_q)
          2'd0: ;
          2'd1: acc_d = mprod_q;
          2'd2: acc_d = acc_q + {mprod_q[31:0], 32'h0};
          default: begin
            we = 1'b1; waddr = AddrW'(sp_q - 2'd2);
            wdata = CellWidth'(acc_q + {mprod_q[31:0], 32'h0});
            sp_d = sp_q - 1'b1; state_d = S_TOP;
          end
        endcase
      end
      S_DIV: begin
        if (ddone) begin
          we = 1'b1; waddr = AddrW'(sp_q - 2'd2); wdata = dres;
          sp_d = sp_q - 1'b1; state_d = S_TOP;
        end
      end
      S_WR2: begin
        we = 1'b1; waddr = AddrW'(sp_q - 1'b1); wdata = r_q; state_d = S_TOP;
      end
      S_WR3: begin
        we = 1'b1; waddr = AddrW'(sp_q - 2'd2); wdata = r_q;
        r_d = c_q; state_d = S_WR2;
      end
      S_TOP: begin
        re      = 1'b1;
        raddr   = AddrW'(sp_q - 1'b1);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sp_q    <= '0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    lit_q  <= lit_d;
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    r_q    <= r_d;
    prn_q  <= prn_d;
    st_q   <= st_d;
    pk_q   <= pk_d;
    mcnt_q <= mcnt_d;
    acc_q  <= acc_d;
  end

  logic [CellWidth-1:0] top_now;
  assign top_now = (sp_q == '0) ? '0 : rdata_q;

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = (state_q == S_OUT);
  assign top_value_o     = PortWidth'($signed(top_now));
  assign stack_depth_o   = DepthWidth'(sp_q);
  assign status_o        = st_q;
  assign print_kind_o    = pk_q;
  assign printed_value_o = PortWidth'($signed(prn_q));

endmodule

// ===== rtl/stack_machine_data_stack_alu_unit.sv =====
// ----------------------------------------------------------------------------
// stack_machine_data_stack_alu_unit
// Data stack and ALU of a stack machine, one operation per request.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry cmd_i and literal_value_i.
// Output channel: out_valid_o / out_stall_i carry the new top, depth,
// status, print kind and printed value of that request.
// One request is in flight at a time. The stack lives in one synchronous
// single-port-read memory, so a request reads its operands one at a time,
// then executes, writes back and reads the top of stack. Status-only
// requests skip the reads; mul forms three 32x32 partial products; swap
// and rot write back in extra states; div/mod wait on the divider.
// Reset empties the stack; memory contents are not cleared.
// While the receiver stalls, the result holds and no request is taken.
// ----------------------------------------------------------------------------
module stack_machine_data_stack_alu_unit import sm_dsa_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDefault,
  parameter int unsigned CellWidth  = CellWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [4:0]            cmd_i,
  input  logic [PortWidth-1:0]  literal_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PortWidth-1:0]  top_value_o,
  output logic [DepthWidth-1:0] stack_depth_o,
  output logic [1:0]            status_o,
  output logic [1:0]            print_kind_o,
  output logic [PortWidth-1:0]  printed_value_o
);

  sm_dsa_ctrl #(.StackDepth(StackDepth), .CellWidth(CellWidth)) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .literal_value_i (literal_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .top_value_o     (top_value_o),
    .stack_depth_o   (stack_depth_o),
    .status_o        (status_o),
    .print_kind_o    (print_kind_o),
    .printed_value_o (printed_value_o)
  );

endmodule

// ===== rtl/sm_dsa_checker.sv =====
// ----------------------------------------------------------------------------
// sm_dsa_checker
// Port-level checks of the data stack ALU.
// ----------------------------------------------------------------------------
module sm_dsa_checker import sm_dsa_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [DepthWidth-1:0] stack_depth_o,
  input logic [1:0]            status_o,
  input logic [1:0]            print_kind_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(stack_depth_o))
    else $error("result dropped under stall");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken while result pending");

  a_err_print: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> print_kind_o == PK_NONE)
    else $error("print on failed request");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken back to back");

endmodule

bind stack_machine_data_stack_alu_unit sm_dsa_checker u_sm_dsa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .stack_depth_o (stack_depth_o),
  .status_o      (status_o),
  .print_kind_o  (print_kind_o)
);

// ===== tb/stack_machine_data_stack_alu_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_machine_data_stack_alu_unit_tb
// Self-checking bench for the data stack ALU: requests of every command,
// including stack underflow, stack overflow, divide by zero, unknown commands
// and signed extremes, are sent, partly under sender gaps and receiver stalls.
// A scoreboard keeps its own stack copy and checks each response in order.
// ----------------------------------------------------------------------------
module stack_machine_data_stack_alu_unit_tb;
  import sm_dsa_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam logic [63:0] MaxCell = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MinCell = 64'h8000_0000_0000_0000;
  localparam logic [63:0] AllOnes = '1;

  typedef struct {
    logic [63:0] top;
    logic [8:0]  depth;
    status_e     status;
    print_kind_e kind;
    logic [63:0] printed;
  } stack_resp_t;

  class stack_scoreboard;
    logic [63:0] cells [StackDepthDefault];
    int unsigned depth;
    stack_resp_t pending [$];
    int unsigned errors;

    function void note_request(logic [4:0] cmd, logic [63:0] lit);
      stack_resp_t exp;
      int unsigned need;
      bit grow;
      logic [63:0] a, b, c, ua, ub, r;
      exp.status = ST_OK;
      exp.kind = PK_NONE;
      exp.printed = '0;
      need = 0;
      grow = 0;
      a = '0;
      b = '0;
      c = '0;
      case (cmd)
        CMD_PUSH: grow = 1;
        CMD_DUP: begin
          need = 1;
          grow = 1;
        end
        CMD_OVER: begin
          need = 2;
          grow = 1;
        end
        CMD_ROT: need = 3;
        CMD_DROP, CMD_INVERT, CMD_PRINT, CMD_EMIT: need = 1;
        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_SWAP,
        CMD_EQ, CMD_LT, CMD_GT, CMD_AND, CMD_OR: need = 2;
        default: need = 0;
      endcase
      if (depth >= 1) b = cells[depth-1];
      if (depth >= 2) a = cells[depth-2];
      if (depth >= 3) c = cells[depth-3];
      if (cmd > CMD_EMIT) begin
      end else if (depth < need) begin
        exp.status = ST_UNDERFLOW;
      end else if (grow && depth >= StackDepthDefault) begin
        exp.status = ST_OVERFLOW;
      end else begin
        case (cmd)
          CMD_PUSH: begin
            cells[depth] = lit;
            depth++;
          end
          CMD_ADD: begin
            cells[depth-2] = a + b;
            depth--;
          end
          CMD_SUB: begin
            cells[depth-2] = a - b;
            depth--;
          end
          CMD_MUL: begin
            cells[depth-2] = a * b;
            depth--;
          end
          CMD_DIV, CMD_MOD: begin
            if (b == 0) begin
              exp.status = ST_DIV_ZERO;
            end else begin
              ua = a[63] ? -a : a;
              ub = b[63] ? -b : b;
              if (cmd == CMD_DIV) begin
                r = ua / ub;
                if (a[63] != b[63]) r = -r;
              end else begin
                r = ua % ub;
                if (a[63]) r = -r;
              end
              cells[depth-2] = r;
              depth--;
            end
          end
          CMD_DUP: begin
            cells[depth] = b;
            depth++;
          end
          CMD_DROP: depth--;
          CMD_SWAP: begin
            cells[depth-2] = b;
            cells[depth-1] = a;
          end
          CMD_OVER: begin
            cells[depth] = a;
            depth++;
          end
          CMD_ROT: begin
            cells[depth-3] = a;
            cells[depth-2] = b;
            cells[depth-1] = c;
          end
          CMD_EQ: begin
            cells[depth-2] = (a == b) ? AllOnes : '0;
            depth--;
          end
          CMD_LT: begin
            cells[depth-2] = ($signed(a) < $signed(b)) ? AllOnes : '0;
            depth--;
          end
          CMD_GT: begin
            cells[depth-2] = ($signed(b) < $signed(a)) ? AllOnes : '0;
            depth--;
          end
          CMD_INVERT: cells[depth-1] = ~b;
          CMD_AND: begin
            cells[depth-2] = a & b;
            depth--;
          end
          CMD_OR: begin
            cells[depth-2] = a | b;
            depth--;
          end
          CMD_PRINT: begin
            exp.kind = PK_NUM;
            exp.printed = b;
            depth--;
          end
          CMD_EMIT: begin
            exp.kind = PK_CHAR;
            exp.printed = b;
            depth--;
          end
          default: ;
        endcase
      end
      exp.top = (depth > 0) ? cells[depth-1] : '0;
      exp.depth = 9'(depth);
      pending.push_back(exp);
    endfunction

    function void check_result(stack_resp_t got);
      stack_resp_t exp;
      if (pending.size() == 0) begin
        $error("unexpected response: top_value %0h", got.top);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.top !== exp.top) begin
        $error("top_value expected %0h got %0h", exp.top, got.top);
        errors++;
      end
      if (got.depth !== exp.depth) begin
        $error("stack_depth expected %0d got %0d", exp.depth, got.depth);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status expected %0d got %0d", exp.status, got.status);
        errors++;
      end
      if (got.kind !== exp.kind) begin
        $error("print_kind expected %0d got %0d", exp.kind, got.kind);
        errors++;
      end
      if (got.printed !== exp.printed) begin
        $error("printed_value expected %0h got %0h", exp.printed, got.printed);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [4:0]  cmd_i;
  logic [63:0] literal_value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] top_value_o;
  logic [8:0]  stack_depth_o;
  logic [1:0]  status_o;
  logic [1:0]  print_kind_o;
  logic [63:0] printed_value_o;

  stack_scoreboard sb = new();
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_cnt = 0;

  stack_machine_data_stack_alu_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .literal_value_i(literal_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .top_value_o    (top_value_o),
    .stack_depth_o  (stack_depth_o),
    .status_o       (status_o),
    .print_kind_o   (print_kind_o),
    .printed_value_o(printed_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result('{top_value_o, stack_depth_o, status_e'(status_o),
                        print_kind_e'(print_kind_o), printed_value_o});
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_req(logic [4:0] cmd, logic [63:0] lit);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= cmd;
    literal_value_i <= lit;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(cmd, lit);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pick_lit();
    case ($urandom_range(5))
      0: return 64'($urandom_range(10)) - 64'd5;
      1: case ($urandom_range(3))
           0: return MaxCell;
           1: return MinCell;
           2: return AllOnes;
           default: return '0;
         endcase
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random();
    int unsigned r;
    logic [4:0] cmd;
    r = $urandom_range(99);
    if (r < 5) begin
      cmd = 5'($urandom_range(31, int'(CMD_EMIT) + 1));
    end else if (sb.depth < 3 && r < 55) begin
      cmd = CMD_PUSH;
    end else if (sb.depth > 24 && r < 60) begin
      case ($urandom_range(3))
        0: cmd = CMD_DROP;
        1: cmd = CMD_ADD;
        2: cmd = CMD_PRINT;
        default: cmd = CMD_EMIT;
      endcase
    end else begin
      cmd = 5'($urandom_range(int'(CMD_EMIT)));
    end
    send_req(cmd, pick_lit());
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    cmd_i           = '0;
    literal_value_i = '0;
    out_stall_i     = 1'b0;
    send_gap_pct    = 0;
    recv_stall_pct  = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(CMD_DROP, '0);
    send_req(CMD_ADD, '0);
    send_req(5'd31, AllOnes);
    send_req(CMD_PUSH, MaxCell);
    send_req(CMD_PUSH, MinCell);
    send_req(CMD_ADD, '0);
    send_req(CMD_PUSH, MinCell);
    send_req(CMD_PUSH, AllOnes);
    send_req(CMD_DIV, '0);
    send_req(CMD_PUSH, AllOnes);
    send_req(CMD_MOD, '0);
    send_req(CMD_PUSH, '0);
    send_req(CMD_DIV, '0);
    send_req(CMD_MOD, '0);
    send_req(CMD_DROP, '0);
    send_req(CMD_PUSH, -64'sd7);
    send_req(CMD_OVER, '0);
    send_req(CMD_ROT, '0);
    send_req(CMD_SWAP, '0);
    send_req(CMD_DUP, '0);
    send_req(CMD_LT, '0);
    send_req(CMD_GT, '0);
    send_req(CMD_EQ, '0);
    send_req(CMD_INVERT, '0);
    send_req(CMD_PUSH, 64'd3);
    send_req(CMD_MUL, '0);
    send_req(CMD_PUSH, 64'd9);
    send_req(CMD_SUB, '0);
    send_req(CMD_AND, '0);
    send_req(CMD_OR, '0);
    send_req(CMD_PRINT, '0);
    send_req(CMD_EMIT, '0);
    send_req(CMD_PRINT, '0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_gap_pct = 58;
          recv_stall_pct = 0;
        end
        2: begin
          send_gap_pct = 0;
          recv_stall_pct = 58;
        end
        default: begin
          send_gap_pct = 37;
          recv_stall_pct = 37;
        end
      endcase
      for (int i = 0; i < 210; i++) begin
        send_random();
        if (i == 105) drain();
      end
    end

    // fill the stack, hit overflow, then empty it and underflow
    while (sb.depth < StackDepthDefault) send_req(CMD_PUSH, pick_lit());
    send_req(CMD_PUSH, pick_lit());
    send_req(CMD_DUP, '0);
    send_req(CMD_OVER, '0);
    send_req(CMD_ROT, '0);
    send_req(CMD_SWAP, '0);
    send_req(CMD_ADD, '0);
    send_req(CMD_PUSH, MaxCell);
    send_req(CMD_PUSH, MinCell);
    while (sb.depth > 0) begin
      case ($urandom_range(2))
        0: send_req(CMD_DROP, '0);
        1: send_req(CMD_PRINT, '0);
        default: send_req(CMD_EMIT, '0);
      endcase
    end
    send_req(CMD_EMIT, '0);
    send_req(CMD_ROT, '0);

    drain();
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
